FILE: hdl/iosdo_pkg.sv
package iosdo_pkg;

  // Timing of the SDO modulator
  localparam longint TSTATE_HZ    = 64'd3579545;
  localparam longint MODULATOR_HZ = 64'd1228800;
  localparam int     CODE_MAX     = 4;                       // highest frequency code
  localparam longint HALF_BASE    = TSTATE_HZ * 64'd32;      // half period at code 0
  localparam longint HALF_MAX     = HALF_BASE << CODE_MAX;   // half period at top code
  localparam int     QMAX         = 1 << CODE_MAX;           // most half periods per tick
  localparam int     ACC_W        = $clog2(HALF_MAX + MODULATOR_HZ);
  localparam int     Q_W          = $clog2(QMAX + 1);

  typedef logic [ACC_W-1:0] acc_t;
  typedef logic [Q_W-1:0]   turns_t;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_TICK  = 3'd2,
    OP_RAISE = 3'd3,
    OP_RESET = 3'd4
  } op_t;

  // Local register ports
  localparam logic [7:0] PORT_PHASE_CLR = 8'h14;
  localparam logic [7:0] PORT_F         = 8'h17;
  localparam logic [7:0] PORT_OPC       = 8'h18;
  localparam logic [7:0] PORT_MSK       = 8'h1A;
  localparam logic [7:0] PORT_IF        = 8'h1B;
  localparam logic [7:0] PORT_DDA       = 8'h1C;
  localparam logic [7:0] PORT_DDB       = 8'h1D;
  localparam logic [7:0] PORT_OPA       = 8'h1E;
  localparam logic [7:0] PORT_OPB       = 8'h1F;
  localparam logic [7:0] PORT_CAUSE     = 8'h32;
  localparam logic [7:0] PORT_IMASK     = 8'h35;

  // Ports owned by neighboring device blocks
  localparam logic [7:0] PORT_DISP_LO   = 8'h20;
  localparam logic [7:0] PORT_DISP_RD   = 8'h27;
  localparam logic [7:0] PORT_DISP_WR   = 8'h2F;
  localparam logic [7:0] PORT_EXT_A     = 8'h31;
  localparam logic [7:0] PORT_EXT_B     = 8'h33;
  localparam logic [7:0] PORT_EXT_C     = 8'h37;
  localparam logic [7:0] PORT_EXT_D     = 8'h38;
  localparam logic [7:0] PORT_EXT_E     = 8'h39;
  localparam logic [7:0] PORT_EXT_F     = 8'h3C;
  localparam logic [7:0] PORT_EXT_G     = 8'h3D;
  localparam logic [7:0] PORT_UART_LO   = 8'h50;
  localparam logic [7:0] PORT_UART_HI   = 8'h5B;
  localparam logic [7:0] PORT_BUS_LO    = 8'h70;
  localparam logic [7:0] PORT_BUS_HI    = 8'h8F;

  localparam logic [7:0] OPEN_BUS       = 8'hFF;
  localparam int         F_ENABLE_BIT   = 6;
  localparam int         ON_KEY_BIT     = 7;
  localparam int         MSK_ON_BIT     = 5;

endpackage

FILE: hdl/io_port_registers_sdo_modulator.sv
// Channel   | Direction | Payload
// s_axis    | in        | tdata: port[7:0], value[15:8], pb_pins[23:16]; tuser: op[2:0]
// m_axis    | out       | tdata: read_data[7:0], sdo_level[8], buzzer_control[16:9],
//           |           |        int_line[17]; tuser: forwarded[0]
//
// One item per clock while the result side does not stall: a transfer lands in the input
// register, then is applied to the register file and the modulator as it moves into the
// result register. The result passes through the input and result registers; a stall on
// the result side holds it in the input register. The modulator step is a single
// combinational pass of parallel constant compares.
// rst (synchronous) empties both stages and resets the valid flags and architectural state registers.
// A stalled result register holds the input stage; a new input is still taken
// whenever the input stage is empty or moving on.
module io_port_registers_sdo_modulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // port, value, pb_pins (low bit up)
  input  logic [2:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // read_data, sdo_level, buzzer_control, int_line, zero pad
  output logic [0:0]  m_axis_tuser    // forwarded
);

  // Input stage
  logic       in_valid;
  logic [2:0] in_op;
  logic [7:0] in_port;
  logic [7:0] in_value;
  logic [7:0] in_pins;

  // Result stage
  logic        out_valid;
  logic [7:0]  out_data;
  logic        out_fwd;

  // Architectural state
  logic [6:0]        f_register, f_register_next;
  logic [7:0]        buzzer_register, buzzer_register_next;
  logic [3:0]        mask_register, mask_register_next;
  logic [7:0]        flag_register, flag_register_next;
  logic [7:0]        direction_a, direction_a_next;
  logic [7:0]        direction_b, direction_b_next;
  logic [7:0]        output_a, output_a_next;
  logic [7:0]        output_b, output_b_next;
  logic [7:0]        interrupt_mask, interrupt_mask_next;
  logic [7:0]        interrupt_cause, interrupt_cause_next;
  logic              sdo_bit, sdo_bit_next;
  iosdo_pkg::acc_t   phase_accumulator, phase_accumulator_next;

  logic       advance;
  logic       fire;
  logic [7:0] data_next;
  logic       fwd_next;

  // Modulator step
  logic [2:0]                  code;
  iosdo_pkg::acc_t             total;
  logic [iosdo_pkg::QMAX-1:0]  passed;
  iosdo_pkg::turns_t           q_base;
  iosdo_pkg::turns_t           q_kept;
  iosdo_pkg::acc_t             tick_acc;
  logic                        tick_flip;

  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  function automatic logic read_fwd(input logic [7:0] p);
    case (p) inside
      [iosdo_pkg::PORT_UART_LO:iosdo_pkg::PORT_UART_HI],
      [iosdo_pkg::PORT_BUS_LO:iosdo_pkg::PORT_BUS_HI],
      [iosdo_pkg::PORT_DISP_LO:iosdo_pkg::PORT_DISP_RD],
      iosdo_pkg::PORT_EXT_A, iosdo_pkg::PORT_EXT_B, iosdo_pkg::PORT_EXT_C: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic write_fwd(input logic [7:0] p);
    case (p) inside
      [iosdo_pkg::PORT_UART_LO:iosdo_pkg::PORT_UART_HI],
      [iosdo_pkg::PORT_BUS_LO:iosdo_pkg::PORT_BUS_HI],
      [iosdo_pkg::PORT_DISP_LO:iosdo_pkg::PORT_DISP_WR],
      iosdo_pkg::PORT_EXT_A, iosdo_pkg::PORT_EXT_C, iosdo_pkg::PORT_EXT_D,
      iosdo_pkg::PORT_EXT_E, iosdo_pkg::PORT_EXT_F, iosdo_pkg::PORT_EXT_G: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Accumulator never exceeds the slowest half period, so one tick passes at
  // most QMAX base half periods; count them with parallel constant compares.
  // Half periods passed at the chosen code = base count >> code.
  always_comb begin
    code  = (f_register[2:0] > 3'(iosdo_pkg::CODE_MAX)) ? 3'(iosdo_pkg::CODE_MAX)
                                                        : f_register[2:0];
    total = phase_accumulator + iosdo_pkg::acc_t'(iosdo_pkg::MODULATOR_HZ);
    for (int k = 1; k <= iosdo_pkg::QMAX; k++) begin
      passed[k-1] = (total >= iosdo_pkg::acc_t'(iosdo_pkg::HALF_BASE * longint'(k)));
    end
    q_base    = iosdo_pkg::turns_t'($countones(passed));
    q_kept    = iosdo_pkg::turns_t'((q_base >> code) << code);
    tick_acc  = total - iosdo_pkg::acc_t'(iosdo_pkg::HALF_BASE) * iosdo_pkg::acc_t'(q_kept);
    tick_flip = q_base[code];
  end

  always_comb begin
    f_register_next        = f_register;
    buzzer_register_next   = buzzer_register;
    mask_register_next     = mask_register;
    flag_register_next     = flag_register;
    direction_a_next       = direction_a;
    direction_b_next       = direction_b;
    output_a_next          = output_a;
    output_b_next          = output_b;
    interrupt_mask_next    = interrupt_mask;
    interrupt_cause_next   = interrupt_cause;
    sdo_bit_next           = sdo_bit;
    phase_accumulator_next = phase_accumulator;
    data_next              = iosdo_pkg::OPEN_BUS;
    fwd_next               = 1'b0;

    unique case (iosdo_pkg::op_t'(in_op))
      iosdo_pkg::OP_READ: begin
        if (read_fwd(in_port)) begin
          fwd_next = 1'b1;
        end else begin
          unique case (in_port)
            iosdo_pkg::PORT_CAUSE: begin
              data_next            = interrupt_cause;
              interrupt_cause_next = '0;     // clear on read
            end
            iosdo_pkg::PORT_IMASK: data_next = interrupt_mask;
            iosdo_pkg::PORT_F:     data_next = {1'b0, f_register};
            iosdo_pkg::PORT_OPC:   data_next = buzzer_register;
            iosdo_pkg::PORT_MSK: begin
              data_next                         = {4'b0, mask_register};
              data_next[iosdo_pkg::MSK_ON_BIT]  = in_pins[iosdo_pkg::ON_KEY_BIT];
            end
            iosdo_pkg::PORT_IF:    data_next = flag_register;
            iosdo_pkg::PORT_DDA:   data_next = direction_a;
            iosdo_pkg::PORT_DDB:   data_next = direction_b;
            iosdo_pkg::PORT_OPA:   data_next = output_a;
            iosdo_pkg::PORT_OPB:   data_next = (output_b & direction_b) | (in_pins & ~direction_b);
            default:               data_next = iosdo_pkg::OPEN_BUS;
          endcase
        end
      end
      iosdo_pkg::OP_WRITE: begin
        if (write_fwd(in_port)) begin
          fwd_next = 1'b1;
        end else begin
          unique case (in_port)
            iosdo_pkg::PORT_IMASK:     interrupt_mask_next    = in_value;
            iosdo_pkg::PORT_OPC:       buzzer_register_next   = in_value;
            iosdo_pkg::PORT_PHASE_CLR: phase_accumulator_next = '0;
            iosdo_pkg::PORT_F: begin
              f_register_next = in_value[6:0];
              if (!in_value[iosdo_pkg::F_ENABLE_BIT]) sdo_bit_next = 1'b1;
            end
            iosdo_pkg::PORT_MSK:       mask_register_next     = in_value[3:0];
            iosdo_pkg::PORT_IF:        flag_register_next     = in_value;
            iosdo_pkg::PORT_DDA:       direction_a_next       = in_value;
            iosdo_pkg::PORT_DDB:       direction_b_next       = in_value;
            iosdo_pkg::PORT_OPA:       output_a_next          = in_value;
            iosdo_pkg::PORT_OPB:       output_b_next          = in_value;
            default: ;
          endcase
        end
      end
      iosdo_pkg::OP_TICK: begin
        if (f_register[iosdo_pkg::F_ENABLE_BIT]) begin
          phase_accumulator_next = tick_acc;
          sdo_bit_next           = sdo_bit ^ tick_flip;
        end
      end
      iosdo_pkg::OP_RAISE: interrupt_cause_next = interrupt_cause | in_value;
      iosdo_pkg::OP_RESET: begin
        f_register_next        = '0;
        sdo_bit_next           = 1'b1;
        phase_accumulator_next = '0;
      end
      default: ;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      out_valid         <= 1'b0;
      f_register        <= '0;
      buzzer_register   <= '0;
      mask_register     <= '0;
      flag_register     <= '0;
      direction_a       <= '0;
      direction_b       <= '0;
      output_a          <= '0;
      output_b          <= '0;
      interrupt_mask    <= '0;
      interrupt_cause   <= '0;
      sdo_bit           <= 1'b1;
      phase_accumulator <= '0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance)       out_valid <= in_valid;
      if (fire) begin
        f_register        <= f_register_next;
        buzzer_register   <= buzzer_register_next;
        mask_register     <= mask_register_next;
        flag_register     <= flag_register_next;
        direction_a       <= direction_a_next;
        direction_b       <= direction_b_next;
        output_a          <= output_a_next;
        output_b          <= output_b_next;
        interrupt_mask    <= interrupt_mask_next;
        interrupt_cause   <= interrupt_cause_next;
        sdo_bit           <= sdo_bit_next;
        phase_accumulator <= phase_accumulator_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_port  <= s_axis_tdata[7:0];
      in_value <= s_axis_tdata[15:8];
      in_pins  <= s_axis_tdata[23:16];
      in_op    <= s_axis_tuser;
    end
    if (fire) begin
      out_data <= data_next;
      out_fwd  <= fwd_next;
    end
  end

  // Level outputs follow the state the last result left behind
  logic sdo_out;
  logic [7:0] opc_out;
  logic int_out;

  always_ff @(posedge clk) begin
    if (fire) begin
      sdo_out <= sdo_bit_next;
      opc_out <= buzzer_register_next;
      int_out <= |(interrupt_cause_next & interrupt_mask_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, int_out, opc_out, sdo_out, out_data};
  assign m_axis_tuser  = out_fwd;

endmodule

FILE: hdl/iosdo_checker.sv
module iosdo_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // An empty result stage never blocks the input side
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // Forwarded accesses read as open bus
  a_fwd_open: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[7:0] == iosdo_pkg::OPEN_BUS)
    else $error("forwarded result with data");

endmodule

bind io_port_registers_sdo_modulator iosdo_checker u_iosdo_checker (.*);
